### rtl/mss_pkg.sv
// shared types and constants for the three-axis stepper ramp scheduler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mss_pkg;

    localparam int AXES          = 3;
    localparam int AX_W          = 2;
    localparam int FRACTION_BITS = 8;
    localparam int TICK_W        = 16;
    localparam int RATE_W        = TICK_W + 2;  // holds 4n+1 for a 16-bit ramp index
    localparam int POS_W         = 32;
    localparam int STEPS_W       = 17;
    localparam int CFG_IDX_W     = 3;

    localparam logic [TICK_W-1:0] IDLE_COMPARE = 16'd65500;
    localparam logic [TICK_W-1:0] INDEX_MAX    = 16'hFFFF;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Z   = 3'd5;

    localparam logic [TICK_W-1:0] START_RESET = 16'd1000;
    localparam logic [TICK_W-1:0] MIN_X_RESET = 16'd100;
    localparam logic [TICK_W-1:0] MIN_Y_RESET = 16'd150;
    localparam logic [TICK_W-1:0] MIN_Z_RESET = 16'd450;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_ARM     = 2'd1,
        ACT_COMPARE = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AXIS,
        ST_RAMP,
        ST_MUL,
        ST_DSTART,
        ST_WAIT,
        ST_ARM,
        ST_EMIT
    } seq_state_t;

endpackage

`default_nettype wire

### rtl/mss_div.sv
// iterative restoring divider, one quotient bit per cycle
// uses no package
`timescale 1ns / 1ps
`default_nettype none

module mss_div #(
    parameter int NUM_W = 42,
    parameter int DEN_W = 18
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic      [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in the next numerator bit, subtract where it fits
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

### rtl/multi_axis_stepper_ramp_scheduler_unit.sv
// three-axis stepper scheduler: per-axis trapezoidal ramps under a small sequencer
// depends on mss_pkg and mss_div
// load and idle words go straight to the emit state, arm words pass through the arm state first
// compare word: axes visited one at a time; a ramp step runs through the divider, which is
// shared by all axes (slowing down passes through a multiply state before it)
// one word in flight at a time; the next is taken once the sequencer is back to idle
// reset clears all axis state, sets compare to 65500 and loads register defaults
`timescale 1ns / 1ps
`default_nettype none

module multi_axis_stepper_ramp_scheduler_unit
    import mss_pkg::*;
#(
    parameter int FRACTION_BITS_P = FRACTION_BITS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TICK_W-1:0]    cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           action,
    input  wire logic [1:0]           axis,
    input  wire logic signed [STEPS_W-1:0] steps,
    input  wire logic [2:0]           endstop_levels,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [2:0]                step_mask,
    output logic [2:0]                dir_mask,
    output logic [TICK_W-1:0]         compare_value,
    output logic [2:0]                running_mask,
    output logic [2:0]                done_mask,
    output logic signed [POS_W-1:0]   position_x,
    output logic signed [POS_W-1:0]   position_y,
    output logic signed [POS_W-1:0]   position_z
);

    localparam int IV_W  = TICK_W + FRACTION_BITS_P;
    localparam int NUM_W = IV_W + RATE_W;
    localparam logic [IV_W-1:0] IV_MAX = {IV_W{1'b1}};

    // configuration
    logic [TICK_W-1:0] start_iv_reg [AXES];
    logic [TICK_W-1:0] min_iv_reg [AXES];

    // axis state
    logic [IV_W-1:0]   iv_reg [AXES],      iv_next [AXES];
    logic [TICK_W-1:0] idx_reg [AXES],     idx_next [AXES];
    logic [TICK_W-1:0] cnt_reg [AXES],     cnt_next [AXES];
    logic [TICK_W-1:0] total_reg [AXES],   total_next [AXES];
    logic [TICK_W-1:0] up_reg [AXES],      up_next [AXES];
    logic [TICK_W-1:0] left_reg [AXES],    left_next [AXES];
    logic [POS_W-1:0]  pos_reg [AXES],     pos_next [AXES];
    logic [AXES-1:0]   dir_reg, dir_next, run_reg, run_next;
    logic [AXES-1:0]   fin_reg, fin_next, due_reg, due_next;
    logic [TICK_W-1:0] cmp_reg, cmp_next;

    // sequencer
    seq_state_t        state_reg, state_next;
    logic [AX_W-1:0]   ax_reg, ax_next;
    logic [TICK_W-1:0] used_reg, used_next;
    logic [AXES-1:0]   stops_reg, stops_next;
    logic [AXES-1:0]   pulse_reg, pulse_next;
    logic              acc_reg, acc_next;
    logic [NUM_W-1:0]  prod_reg, prod_next;
    logic [RATE_W-1:0] den_reg, den_next;

    // result word
    logic              out_valid_reg, out_valid_next;
    logic [2:0]        step_reg, dirm_reg, runm_reg, finm_reg;
    logic [TICK_W-1:0] cmpo_reg;
    logic [POS_W-1:0]  posx_reg, posy_reg, posz_reg;

    logic              div_start;
    logic              div_done;
    logic [NUM_W-1:0]  div_quo;

    mss_div #(
        .NUM_W(NUM_W),
        .DEN_W(RATE_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // arm: soonest running axes
    logic              arm_any;
    logic [TICK_W-1:0] arm_best;
    logic [AXES-1:0]   arm_due;

    always_comb
    begin
        arm_any  = 1'b0;
        arm_best = '0;
        arm_due  = '0;
        for (int i = 0; i < AXES; i++)
        begin
            if (run_reg[i] && (!arm_any || left_reg[i] < arm_best))
            begin
                arm_best = left_reg[i];
                arm_any  = 1'b1;
            end
        end
        for (int i = 0; i < AXES; i++)
        begin
            if (run_reg[i] && left_reg[i] == arm_best)
                arm_due[i] = 1'b1;
        end
    end

    logic [STEPS_W-1:0] load_mag;
    logic [TICK_W-1:0]  load_count;
    logic               last_axis;
    logic [TICK_W-1:0]  cur_cnt;
    logic [TICK_W-1:0]  cur_idx;
    logic [TICK_W-1:0]  idx_inc;
    logic [IV_W-1:0]    cur_iv;
    logic [IV_W-1:0]    lim;
    logic [IV_W-1:0]    d_new;

    always_comb
    begin
        iv_next    = iv_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        total_next = total_reg;
        up_next    = up_reg;
        left_next  = left_reg;
        pos_next   = pos_reg;
        dir_next   = dir_reg;
        run_next   = run_reg;
        fin_next   = fin_reg;
        due_next   = due_reg;
        cmp_next   = cmp_reg;
        state_next = state_reg;
        ax_next    = ax_reg;
        used_next  = used_reg;
        stops_next = stops_reg;
        pulse_next = pulse_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        den_next   = den_reg;
        div_start  = 1'b0;
        in_ready   = (state_reg == ST_IDLE);

        load_mag   = steps[STEPS_W-1] ? (~$unsigned(steps) + STEPS_W'(1)) : $unsigned(steps);
        load_count = load_mag[STEPS_W-1] ? INDEX_MAX : load_mag[TICK_W-1:0];
        last_axis  = (ax_reg == AX_W'(AXES - 1));
        cur_cnt    = cnt_reg[ax_reg];
        cur_idx    = idx_reg[ax_reg];
        cur_iv     = iv_reg[ax_reg];
        idx_inc    = (cur_idx == INDEX_MAX) ? cur_idx : cur_idx + TICK_W'(1);
        lim        = {min_iv_reg[ax_reg], {FRACTION_BITS_P{1'b0}}};
        d_new      = cur_iv;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    pulse_next = '0;
                    unique case (action_t'(action))
                        ACT_LOAD:
                        begin
                            if (axis < AX_W'(AXES))
                            begin
                                dir_next[axis]   = steps[STEPS_W-1];
                                total_next[axis] = load_count;
                                iv_next[axis]    = {start_iv_reg[axis], {FRACTION_BITS_P{1'b0}}};
                                left_next[axis]  = start_iv_reg[axis];
                                cnt_next[axis]   = '0;
                                idx_next[axis]   = '0;
                                up_next[axis]    = '0;
                                fin_next[axis]   = (load_count == '0);
                                run_next[axis]   = (load_count != '0);
                            end
                            state_next = ST_EMIT;
                        end
                        ACT_ARM:
                            state_next = ST_ARM;
                        ACT_COMPARE:
                        begin
                            used_next  = cmp_reg;
                            stops_next = endstop_levels;
                            ax_next    = '0;
                            state_next = ST_AXIS;
                        end
                        default:
                            state_next = ST_EMIT;
                    endcase
                end
            end

            ST_AXIS:
            begin
                if (run_reg[ax_reg] && due_reg[ax_reg])
                begin
                    if (cur_cnt < total_reg[ax_reg])
                    begin
                        pulse_next[ax_reg] = 1'b1;
                        cnt_next[ax_reg]   = cur_cnt + TICK_W'(1);
                        pos_next[ax_reg]   = dir_reg[ax_reg] ? pos_reg[ax_reg] - POS_W'(1)
                                                             : pos_reg[ax_reg] + POS_W'(1);
                        if (cur_cnt + TICK_W'(1) >= total_reg[ax_reg] || !stops_reg[ax_reg])
                        begin
                            fin_next[ax_reg] = 1'b1;
                            run_next[ax_reg] = 1'b0;
                        end
                    end
                    state_next = ST_RAMP;
                end
                else
                begin
                    // waiting axes age by the compare value just used
                    if (run_reg[ax_reg])
                        left_next[ax_reg] = (left_reg[ax_reg] > used_reg)
                                            ? left_reg[ax_reg] - used_reg : '0;
                    ax_next    = ax_reg + AX_W'(1);
                    state_next = last_axis ? ST_ARM : ST_AXIS;
                end
            end

            ST_RAMP:
            begin
                if (up_reg[ax_reg] == '0)
                begin
                    // speeding up: d -= 2d / (4n + 1)
                    idx_next[ax_reg] = idx_inc;
                    prod_next        = NUM_W'({cur_iv, 1'b0});
                    den_next         = {idx_inc, 2'b01};
                    acc_next         = 1'b1;
                    state_next       = ST_DSTART;
                end
                else if (cur_cnt >= total_reg[ax_reg] - up_reg[ax_reg] && cur_idx != '0)
                begin
                    acc_next   = 1'b0;
                    den_next   = {cur_idx, 2'b00} - RATE_W'(1);
                    state_next = ST_MUL;
                end
                else
                begin
                    left_next[ax_reg] = cur_iv[FRACTION_BITS_P +: TICK_W];
                    ax_next           = ax_reg + AX_W'(1);
                    state_next        = last_axis ? ST_ARM : ST_AXIS;
                end
            end

            ST_MUL:
            begin
                // slowing down: d * (4n + 1), divided next by 4n - 1
                prod_next  = cur_iv * {cur_idx, 2'b01};
                state_next = ST_DSTART;
            end

            ST_DSTART:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end

            ST_WAIT:
            begin
                if (div_done)
                begin
                    if (acc_reg)
                    begin
                        d_new = cur_iv - div_quo[IV_W-1:0];
                        if (d_new <= lim)
                        begin
                            d_new           = lim;
                            up_next[ax_reg] = cur_cnt;
                        end
                        if (cur_cnt >= (total_reg[ax_reg] >> 1))
                            up_next[ax_reg] = cur_cnt;
                    end
                    else
                    begin
                        d_new = (div_quo > NUM_W'(IV_MAX)) ? IV_MAX : div_quo[IV_W-1:0];
                        idx_next[ax_reg] = cur_idx - TICK_W'(1);
                    end
                    iv_next[ax_reg]   = d_new;
                    left_next[ax_reg] = d_new[FRACTION_BITS_P +: TICK_W];
                    ax_next           = ax_reg + AX_W'(1);
                    state_next        = last_axis ? ST_ARM : ST_AXIS;
                end
            end

            ST_ARM:
            begin
                due_next   = arm_due;
                cmp_next   = arm_any ? arm_best : IDLE_COMPARE;
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    assign out_valid_next = (state_reg == ST_EMIT) ? 1'b1
                          : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                iv_reg[i]    <= '0;
                idx_reg[i]   <= '0;
                cnt_reg[i]   <= '0;
                total_reg[i] <= '0;
                up_reg[i]    <= '0;
                left_reg[i]  <= '0;
                pos_reg[i]   <= '0;
            end
            start_iv_reg[0] <= START_RESET;
            start_iv_reg[1] <= START_RESET;
            start_iv_reg[2] <= START_RESET;
            min_iv_reg[0]   <= MIN_X_RESET;
            min_iv_reg[1]   <= MIN_Y_RESET;
            min_iv_reg[2]   <= MIN_Z_RESET;
            dir_reg       <= '0;
            run_reg       <= '0;
            fin_reg       <= '0;
            due_reg       <= '0;
            cmp_reg       <= IDLE_COMPARE;
            state_reg     <= ST_IDLE;
            ax_reg        <= '0;
            acc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            iv_reg        <= iv_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            total_reg     <= total_next;
            up_reg        <= up_next;
            left_reg      <= left_next;
            pos_reg       <= pos_next;
            dir_reg       <= dir_next;
            run_reg       <= run_next;
            fin_reg       <= fin_next;
            due_reg       <= due_next;
            cmp_reg       <= cmp_next;
            state_reg     <= state_next;
            ax_reg        <= ax_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_START_X: start_iv_reg[0] <= cfg_data;
                    REG_START_Y: start_iv_reg[1] <= cfg_data;
                    REG_START_Z: start_iv_reg[2] <= cfg_data;
                    REG_MIN_X:   min_iv_reg[0]   <= cfg_data;
                    REG_MIN_Y:   min_iv_reg[1]   <= cfg_data;
                    REG_MIN_Z:   min_iv_reg[2]   <= cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        used_reg  <= used_next;
        stops_reg <= stops_next;
        pulse_reg <= pulse_next;
        prod_reg  <= prod_next;
        den_reg   <= den_next;
        if (state_reg == ST_EMIT && (!out_valid_reg || out_ready))
        begin
            step_reg <= pulse_reg;
            dirm_reg <= dir_reg;
            cmpo_reg <= cmp_reg;
            runm_reg <= run_reg;
            finm_reg <= fin_reg;
            posx_reg <= pos_reg[0];
            posy_reg <= pos_reg[1];
            posz_reg <= pos_reg[2];
        end
    end

    assign out_valid     = out_valid_reg;
    assign step_mask     = step_reg;
    assign dir_mask      = dirm_reg;
    assign compare_value = cmpo_reg;
    assign running_mask  = runm_reg;
    assign done_mask     = finm_reg;
    assign position_x    = $signed(posx_reg);
    assign position_y    = $signed(posy_reg);
    assign position_z    = $signed(posz_reg);

endmodule

`default_nettype wire
